### rtl/watchdog_timer_with_prescaler_defines.svh
// Assertion macros for the checker in wdtp_checker.sv.
`ifndef WATCHDOG_TIMER_WITH_PRESCALER_DEFINES_SVH
`define WATCHDOG_TIMER_WITH_PRESCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WDTP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog check failed");

// Next-cycle implication, disabled while reset is high.
`define WDTP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog check failed");

`endif

### rtl/wdtp_pkg.sv
package wdtp_pkg;

  localparam int unsigned CYCLE_W   = 35;
  localparam int unsigned CPM_W     = 16;
  localparam int unsigned TMO_W     = 8;
  localparam int unsigned SEL_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam int unsigned MAX_PERIOD_SELECT_DEF = 18;

  localparam logic [SEL_W-1:0] SEL_SOFTWARE = 5'd31;

  typedef enum logic [1:0] {
    EN_OFF    = 2'd0,
    EN_ALWAYS = 2'd1,
    EN_AWAKE  = 2'd2,
    EN_SW     = 2'd3
  } en_mode_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_WAKE  = 2'd1;
  localparam logic [1:0] EV_RESET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUTS      = 2'd3;

  localparam logic [CPM_W-1:0] CPM_RESET      = 16'd1000;
  localparam logic [TMO_W-1:0] TIMEOUTS_RESET = 8'd1;

endpackage

### rtl/watchdog_timer_with_prescaler.sv
// Watchdog with a millisecond prescaler. Each input word is one instruction
// cycle tick or a clear; every word gives exactly one result word. A word is
// taken every clock when the output side keeps up. A word waits in the input
// register until the output side is free; the counter update runs between the
// input register and the result register, where the result is held until
// taken. The input register lets a new word in while a result still waits
// at the output. A period ends when the elapsed cycle count exceeds
// cycles_per_ms shifted left by the period select (a select above
// MAX_PERIOD_SELECT counts as 0, a select of 31 takes the word's sw_period);
// after timeouts_to_reset periods the block reports a wake when asleep, otherwise
// a device reset. Write configuration only while no word is in flight.
module watchdog_timer_with_prescaler #(
  parameter int unsigned MAX_PERIOD_SELECT = wdtp_pkg::MAX_PERIOD_SELECT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wdtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdtp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic                            asleep,
  input  logic                            sw_enable,
  input  logic [wdtp_pkg::SEL_W-1:0]      sw_period,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_res,
  output logic [wdtp_pkg::TMO_W-1:0]      period_count,
  output logic                            counting
);

  localparam int unsigned CYCLE_W = wdtp_pkg::CYCLE_W;
  localparam int unsigned TMO_W   = wdtp_pkg::TMO_W;
  localparam int unsigned SEL_W   = wdtp_pkg::SEL_W;
  localparam int unsigned THR_W   = wdtp_pkg::CPM_W + MAX_PERIOD_SELECT;
  localparam int unsigned CMP_W   = (THR_W > CYCLE_W) ? THR_W : CYCLE_W;

  // configuration
  wdtp_pkg::en_mode_t              enable_mode;
  logic [SEL_W-1:0]                period_select;
  logic [wdtp_pkg::CPM_W-1:0]      cycles_per_ms;
  logic [TMO_W-1:0]                timeouts_to_reset;

  // input register
  logic                            in_full;
  logic                            in_opcode;
  logic                            in_asleep;
  logic                            in_sw_enable;
  logic [SEL_W-1:0]                in_sw_period;

  // watchdog state
  logic [CYCLE_W-1:0]              cycle_count;
  logic [CYCLE_W-1:0]              cycle_count_next;
  logic [TMO_W-1:0]                timeout_count;
  logic [TMO_W-1:0]                timeout_count_next;

  logic                            advance;
  logic                            enabled;
  logic [SEL_W-1:0]                sel_raw;
  logic [SEL_W-1:0]                sel;
  logic [THR_W-1:0]                threshold;
  logic [CYCLE_W-1:0]              cycle_inc;
  logic                            period_end;
  logic [TMO_W-1:0]                timeout_inc;
  logic [1:0]                      event_next;
  logic                            counting_next;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mode       <= wdtp_pkg::EN_OFF;
      period_select     <= wdtp_pkg::SEL_SOFTWARE;
      cycles_per_ms     <= wdtp_pkg::CPM_RESET;
      timeouts_to_reset <= wdtp_pkg::TIMEOUTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wdtp_pkg::CFG_ENABLE_MODE:   enable_mode <= wdtp_pkg::en_mode_t'(cfg_data[1:0]);
        wdtp_pkg::CFG_PERIOD_SELECT: period_select <= cfg_data[SEL_W-1:0];
        wdtp_pkg::CFG_CYCLES_PER_MS: cycles_per_ms <= cfg_data;
        wdtp_pkg::CFG_TIMEOUTS:      timeouts_to_reset <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_opcode    <= opcode;
      in_asleep    <= asleep;
      in_sw_enable <= sw_enable;
      in_sw_period <= sw_period;
    end
  end

  always_comb begin
    unique case (enable_mode)
      wdtp_pkg::EN_OFF:    enabled = 1'b0;
      wdtp_pkg::EN_ALWAYS: enabled = 1'b1;
      wdtp_pkg::EN_AWAKE:  enabled = !in_asleep;
      wdtp_pkg::EN_SW:     enabled = in_sw_enable;
      default:             enabled = 1'b0;
    endcase
  end

  assign sel_raw   = (period_select == wdtp_pkg::SEL_SOFTWARE) ? in_sw_period : period_select;
  assign sel       = (sel_raw > SEL_W'(MAX_PERIOD_SELECT)) ? '0 : sel_raw;
  assign threshold = THR_W'(cycles_per_ms) << sel;
  // saturate at all ones
  assign cycle_inc   = (cycle_count == '1) ? cycle_count : cycle_count + CYCLE_W'(1);
  assign period_end  = CMP_W'(cycle_inc) > CMP_W'(threshold);
  assign timeout_inc = timeout_count + TMO_W'(1);

  always_comb begin
    cycle_count_next   = cycle_count;
    timeout_count_next = timeout_count;
    event_next         = wdtp_pkg::EV_NONE;
    counting_next      = 1'b0;
    if (in_opcode == wdtp_pkg::OP_CLEAR) begin
      cycle_count_next   = '0;
      timeout_count_next = '0;
    end else if (enabled) begin
      counting_next    = 1'b1;
      cycle_count_next = cycle_inc;
      if (period_end) begin
        cycle_count_next = '0;
        if (timeout_inc == timeouts_to_reset) begin
          timeout_count_next = '0;
          event_next = in_asleep ? wdtp_pkg::EV_WAKE : wdtp_pkg::EV_RESET;
        end else begin
          timeout_count_next = timeout_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count   <= '0;
      timeout_count <= '0;
    end else if (advance) begin
      cycle_count   <= cycle_count_next;
      timeout_count <= timeout_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      event_res    <= event_next;
      period_count <= timeout_count_next;
      counting     <= counting_next;
    end
  end

endmodule

### rtl/wdtp_checker.sv
`include "watchdog_timer_with_prescaler_defines.svh"

module wdtp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      event_res,
  input logic [wdtp_pkg::TMO_W-1:0]      period_count,
  input logic                            counting
);

  // a wake or reset always empties the timeout count
  `WDTP_ASSERT_IMP(a_event_clears, clk, rst, out_valid && event_res != wdtp_pkg::EV_NONE, period_count == '0)

  // events only come from ticks that counted
  `WDTP_ASSERT_IMP(a_event_counting, clk, rst, out_valid && !counting, event_res == wdtp_pkg::EV_NONE)

  // the input only stalls behind a result word that is not being taken
  `WDTP_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // a stalled result word holds
  `WDTP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(period_count) && $stable(counting))

endmodule

bind watchdog_timer_with_prescaler wdtp_checker u_wdtp_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wdtp_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 12;
  localparam int SETTLE      = 4;
  localparam int HOLD_LEN    = 60;
  localparam int ITEMS_TOTAL = 1550;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]       ev;
    logic [TMO_W-1:0] periods;
    logic             active;
  } wd_report_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE_MODE;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 opcode    = OP_TICK;
  logic                 asleep    = 1'b0;
  logic                 sw_enable = 1'b0;
  logic [SEL_W-1:0]     sw_period = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           event_res;
  logic [TMO_W-1:0]     period_count;
  logic                 counting;

  // Shadow of the watchdog registers and counters
  en_mode_t           mode_q    = EN_OFF;
  logic [SEL_W-1:0]   sel_q     = SEL_SOFTWARE;
  logic [CPM_W-1:0]   cpm_q     = CPM_RESET;
  logic [TMO_W-1:0]   limit_q   = TIMEOUTS_RESET;
  logic [CYCLE_W-1:0] elapsed_q = '0;
  logic [TMO_W-1:0]   periods_q = '0;

  wd_report_t pending_reports[$];

  bit steady    = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int fail_count      = 0;
  int words_sent      = 0;
  int reports_checked = 0;
  int wakes_seen      = 0;
  int resets_seen     = 0;
  int cycle_no        = 0;

  watchdog_timer_with_prescaler i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .asleep       (asleep),
    .sw_enable    (sw_enable),
    .sw_period    (sw_period),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .period_count (period_count),
    .counting     (counting)
  );

  always #CLK_HALF clk = ~clk;

  function automatic wd_report_t watchdog_step(logic op, logic slp, logic swen,
                                               logic [SEL_W-1:0] swp);
    wd_report_t         r;
    logic               on;
    logic [SEL_W-1:0]   sel;
    logic [CYCLE_W-1:0] limit_cycles;
    r = '{ev: EV_NONE, periods: '0, active: 1'b0};
    case (mode_q)
      EN_ALWAYS: on = 1'b1;
      EN_AWAKE:  on = !slp;
      EN_SW:     on = swen;
      default:   on = 1'b0;
    endcase
    if (op == OP_CLEAR) begin
      elapsed_q = '0;
      periods_q = '0;
    end else if (on) begin
      r.active = 1'b1;
      sel = (sel_q == SEL_SOFTWARE) ? swp : sel_q;
      if (sel > MAX_PERIOD_SELECT_DEF) sel = '0;
      limit_cycles = CYCLE_W'(cpm_q) << sel;
      // saturate rather than wrap
      if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
      if (elapsed_q > limit_cycles) begin
        elapsed_q = '0;
        periods_q = periods_q + 1'b1;
        if (periods_q == limit_q) begin
          periods_q = '0;
          r.ev = slp ? EV_WAKE : EV_RESET;
        end
      end
    end
    r.periods = periods_q;
    return r;
  endfunction

  // Offer one word, hold it until taken, then log its expected result
  task automatic send_word(logic op, logic slp, logic swen, logic [SEL_W-1:0] swp);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    asleep    <= slp;
    sw_enable <= swen;
    sw_period <= swp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(watchdog_step(op, slp, swen, swp));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENABLE_MODE:   mode_q  = en_mode_t'(val[1:0]);
      CFG_PERIOD_SELECT: sel_q   = val[SEL_W-1:0];
      CFG_CYCLES_PER_MS: cpm_q   = val[CPM_W-1:0];
      default:           limit_q = val[TMO_W-1:0];
    endcase
  endtask

  task automatic configure(en_mode_t mode, logic [SEL_W-1:0] sel,
                           logic [CPM_W-1:0] cpm, logic [TMO_W-1:0] lim);
    drain();
    write_reg(CFG_ENABLE_MODE, CFG_W'(mode));
    write_reg(CFG_PERIOD_SELECT, CFG_W'(sel));
    write_reg(CFG_CYCLES_PER_MS, CFG_W'(cpm));
    write_reg(CFG_TIMEOUTS, CFG_W'(lim));
  endtask

  // Out of reset the watchdog is off; then switch it on with the other
  // registers left at their reset values
  task automatic test_reset_state();
    send_word(OP_TICK, 1'b0, 1'b1, 5'd0);
    send_word(OP_TICK, 1'b1, 1'b1, 5'd31);
    send_word(OP_CLEAR, 1'b0, 1'b0, 5'd0);
    drain();
    write_reg(CFG_ENABLE_MODE, CFG_W'(EN_ALWAYS));
    repeat (4) send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b1, 1'b1, 5'd31);
  endtask

  task automatic test_directed();
    configure(EN_ALWAYS, 5'd0, 16'd1, 8'd1);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b1, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b1, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_CLEAR, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    // zero cycles per ms: every enabled tick closes a period
    configure(EN_AWAKE, 5'd0, 16'd0, 8'd2);
    send_word(OP_TICK, 1'b1, 1'b1, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd0);
    configure(EN_SW, SEL_SOFTWARE, 16'd1, 8'd1);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd31);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd31);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd31);
    send_word(OP_TICK, 1'b1, 1'b1, 5'd18);
    // an oversized register select falls back to zero
    configure(EN_ALWAYS, 5'd19, 16'd1, 8'd255);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 5'd0);
    configure(EN_ALWAYS, 5'd18, 16'hFFFF, 8'd255);
    send_word(OP_TICK, 1'b1, 1'b0, 5'd0);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd0);
    configure(EN_OFF, 5'd0, 16'd0, 8'd1);
    send_word(OP_TICK, 1'b0, 1'b1, 5'd0);
    send_word(OP_CLEAR, 1'b1, 1'b1, 5'd31);
  endtask

  // A limit of zero only fires once the timeout count wraps past 255
  task automatic test_timeout_wrap();
    configure(EN_ALWAYS, 5'd0, 16'd0, 8'd0);
    repeat (258) send_word(OP_TICK, 1'($urandom), 1'($urandom), 5'($urandom));
    configure(EN_ALWAYS, 5'd0, 16'd0, 8'd255);
    repeat (256) send_word(OP_TICK, 1'($urandom), 1'($urandom), 5'd0);
  endtask

  // Stall the output long enough for the pipe to back up into the input
  task automatic test_backpressure();
    configure(EN_ALWAYS, 5'd1, 16'd1, 8'd3);
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (48) send_word(OP_TICK, 1'($urandom), 1'b0, 5'd0);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random();
    en_mode_t         mode;
    logic [SEL_W-1:0] sel;
    logic [CPM_W-1:0] cpm;
    logic [TMO_W-1:0] lim;
    logic [SEL_W-1:0] phase_swp;
    logic             op;
    logic             slp;
    logic             swen;
    logic [SEL_W-1:0] swp;
    int               sleep_pct;
    int               n;
    int               r;
    while (words_sent < ITEMS_TOTAL) begin
      mode = ($urandom_range(9) == 0) ? EN_OFF : en_mode_t'($urandom_range(1, 3));
      r = $urandom_range(9);
      if (r < 5)      sel = 5'($urandom_range(0, 2));
      else if (r < 8) sel = SEL_SOFTWARE;
      else if (r < 9) sel = 5'($urandom_range(19, 30));
      else            sel = 5'($urandom_range(3, 18));
      r = $urandom_range(9);
      if (r < 6)      cpm = 16'($urandom_range(0, 3));
      else if (r < 9) cpm = 16'($urandom_range(4, 40));
      else            cpm = 16'($urandom);
      r = $urandom_range(9);
      if (r < 7)      lim = 8'($urandom_range(1, 4));
      else if (r < 9) lim = 8'($urandom);
      else            lim = $urandom_range(1) ? 8'd255 : 8'd0;
      configure(mode, sel, cpm, lim);
      phase_swp = ($urandom_range(3) == 0) ? 5'($urandom_range(19, 31))
                                            : 5'($urandom_range(0, 2));
      sleep_pct = $urandom_range(100);
      n = $urandom_range(20, 80);
      // about one phase in eight runs with neither side idling
      steady = ($urandom_range(7) == 0);
      repeat (n) begin
        op   = ($urandom_range(99) < 4) ? OP_CLEAR : OP_TICK;
        slp  = ($urandom_range(99) < sleep_pct);
        swen = ($urandom_range(9) != 0);
        swp  = ($urandom_range(99) < 85) ? phase_swp : 5'($urandom);
        send_word(op, slp, swen, swp);
      end
      steady = 1'b0;
    end
  endtask

  // Output side: random stalls, or a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin : check_block
    wd_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: event_res %0d period_count %0d counting %0d",
               event_res, period_count, counting);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, event_res);
          fail_count++;
        end
        if (period_count !== want.periods) begin
          $error("period_count: expected %0d, got %0d", want.periods, period_count);
          fail_count++;
        end
        if (counting !== want.active) begin
          $error("counting: expected %0d, got %0d", want.active, counting);
          fail_count++;
        end
        reports_checked++;
        if (want.ev == EV_WAKE)  wakes_seen++;
        if (want.ev == EV_RESET) resets_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles with %0d results outstanding",
             cycle_no, pending_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_timeout_wrap();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d words and checked %0d results (%0d wakes, %0d device resets).",
             words_sent, reports_checked, wakes_seen, resets_seen);
    $display("Covered all enable modes, register and software period selects, timeout wrap,");
    $display("zero and full-scale prescaler settings and a long output stall.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/wdtp_pkg.sv
rtl/watchdog_timer_with_prescaler.sv
rtl/wdtp_checker.sv
tb/tb_top.sv
